// ===== rtl/core/hll_pkg.sv =====
// ----------------------------------------------------------------------------
// hll_pkg
// Shared constants, command/status types and helpers for the sketch.
// ----------------------------------------------------------------------------
`default_nettype none
package hll_pkg;

   localparam int LOG_MAX_BUCKETS = 14;
   localparam int MAX_BUCKETS     = 1 << LOG_MAX_BUCKETS;
   localparam int LW              = $clog2(LOG_MAX_BUCKETS + 1);
   localparam int RANK_W          = 5;
   localparam int SUM_W           = 44;
   localparam int EMPTY_W         = 15;
   localparam int BIAS_W          = 16;
   localparam int NUM_W           = BIAS_W + 2 * LOG_MAX_BUCKETS + 13;
   localparam int CNT_W           = $clog2(NUM_W);
   localparam int LOG_ITERS       = 32;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [LW-1:0] LOG_RESET  = LW'(10);
   localparam logic [BIAS_W-1:0] BIAS_RESET = 16'd47221;

   localparam logic REG_LOG_BUCKETS = 1'b0;
   localparam logic REG_BIAS        = 1'b1;

   typedef struct packed {
      logic                       clr_init;
      logic                       clr_wr;
      logic [LOG_MAX_BUCKETS-1:0] clr_addr;
      logic                       accept;
      logic                       ins_upd;
      logic                       div_step;
      logic                       div_end;
      logic                       decide;
      logic                       log_norm;
      logic                       log_step;
      logic                       ln_mul;
      logic                       ln_res;
      logic                       load_out;
   } cmd_type;

   typedef struct packed {
      logic need_log;
   } sts_type;

   function automatic logic [LW-1:0] eff_log(input logic [3:0] raw);
      logic [LW-1:0] l;
      l = LW'(raw);
      if (raw < 4'd4) l = LW'(4);
      if (raw > 4'd14) l = LW'(14);
      if (32'(l) > LOG_MAX_BUCKETS) l = LW'(LOG_MAX_BUCKETS);
      return l;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hyperloglog_cardinality_sketch.sv =====
// ----------------------------------------------------------------------------
// hyperloglog_cardinality_sketch
// HyperLogLog distinct-count sketch over externally computed 32-bit hashes.
// ----------------------------------------------------------------------------
//  channel | ports                                | word
//  req     | req_valid/req_ready                  | req_mode, req_hash_value
//  rsp     | rsp_valid/rsp_ready                  | rsp_estimate
//  csr     | csr_psel/penable/pwrite/paddr/pwdata | log_buckets @0, bias_q16 @4
//
//  Insert: bucket read, then compare and write back.
//  Read: restoring divider, plus normalize, 32 log2 squaring steps and ln
//  scaling when a correction applies.
//  After reset and after every log_buckets write the whole rank memory is
//  swept, with req_ready low.
//  A waiting rsp word does not stop inserts; a read stalls only at its end.
// ----------------------------------------------------------------------------
`default_nettype none
module hyperloglog_cardinality_sketch (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [31:0] req_hash_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_estimate,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [3:0]                     log_ff;
   logic [hll_pkg::BIAS_W-1:0]     bias_ff;
   logic                           wr, clr_req;
   hll_pkg::cmd_type               cmd;
   hll_pkg::sts_type               sts;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign clr_req    = wr && (csr_paddr[2] == hll_pkg::REG_LOG_BUCKETS);

   always_ff @(posedge clock) begin
      if (reset) begin
         log_ff  <= 4'(hll_pkg::LOG_RESET);
         bias_ff <= hll_pkg::BIAS_RESET;
      end else if (wr) begin
         unique case (csr_paddr[2])
            hll_pkg::REG_LOG_BUCKETS: log_ff  <= csr_pwdata[3:0];
            hll_pkg::REG_BIAS:        bias_ff <= csr_pwdata[15:0];
            default:                  log_ff  <= log_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         hll_pkg::REG_LOG_BUCKETS: csr_prdata = 32'(log_ff);
         hll_pkg::REG_BIAS:        csr_prdata = 32'(bias_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   hll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .clr_req   (clr_req),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   hll_dp u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .sts            (sts),
      .log_k          (hll_pkg::eff_log(log_ff)),
      .bias           (bias_ff),
      .req_hash_value (req_hash_value),
      .rsp_estimate   (rsp_estimate)
   );

endmodule
`default_nettype wire

// ===== rtl/core/hll_ram.sv =====
// ----------------------------------------------------------------------------
// hll_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module hll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/core/hll_ctrl.sv =====
// ----------------------------------------------------------------------------
// hll_ctrl
// Sequencer: store clearing, insert, division, log iterations, result word.
// ----------------------------------------------------------------------------
`default_nettype none
module hll_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clr_req,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_mode,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output hll_pkg::cmd_type      cmd,
   input  wire hll_pkg::sts_type sts
);

   typedef enum logic [3:0] {
      ST_CLR_INIT, ST_CLEAR, ST_IDLE, ST_INS, ST_DIV, ST_DIV_END, ST_DECIDE,
      ST_LOG_NORM, ST_LOG_ITER, ST_LN_MUL, ST_LN_RES, ST_OUT
   } state_type;

   state_type                            state_ff, state_in;
   logic [hll_pkg::CNT_W-1:0]            cnt_ff, cnt_in;
   logic [hll_pkg::LOG_MAX_BUCKETS-1:0]  addr_ff, addr_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.clr_addr = addr_ff;
      unique case (state_ff)
         ST_CLR_INIT: begin
            cmd.clr_init = 1'b1;
            addr_in      = '0;
            state_in     = ST_CLEAR;
         end
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            addr_in    = addr_ff + 1'b1;
            if (&addr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               state_in   = req_mode ? ST_DIV : ST_INS;
            end
         end
         ST_INS: begin
            cmd.ins_upd = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == hll_pkg::CNT_W'(hll_pkg::NUM_W - 1)) state_in = ST_DIV_END;
         end
         ST_DIV_END: begin
            cmd.div_end = 1'b1;
            state_in    = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = sts.need_log ? ST_LOG_NORM : ST_OUT;
         end
         ST_LOG_NORM: begin
            cmd.log_norm = 1'b1;
            cnt_in       = '0;
            state_in     = ST_LOG_ITER;
         end
         ST_LOG_ITER: begin
            cmd.log_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == hll_pkg::CNT_W'(hll_pkg::LOG_ITERS - 1)) state_in = ST_LN_MUL;
         end
         ST_LN_MUL: begin
            cmd.ln_mul = 1'b1;
            state_in   = ST_LN_RES;
         end
         ST_LN_RES: begin
            cmd.ln_res = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (clr_req) state_in = ST_CLR_INIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR_INIT;
         cnt_ff       <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/hll_dp.sv =====
// ----------------------------------------------------------------------------
// hll_dp
// Datapath: rank store, harmonic sum, divider, log2 unit and corrections.
// ----------------------------------------------------------------------------
`default_nettype none
module hll_dp (
   input  wire logic                          clock,
   input  wire hll_pkg::cmd_type              cmd,
   output hll_pkg::sts_type                   sts,
   input  wire logic [hll_pkg::LW-1:0]        log_k,
   input  wire logic [hll_pkg::BIAS_W-1:0]    bias,
   input  wire logic [31:0]                   req_hash_value,
   output logic      [31:0]                   rsp_estimate
);

   localparam int LMB = hll_pkg::LOG_MAX_BUCKETS;
   localparam int NW  = hll_pkg::NUM_W;
   localparam int SW  = hll_pkg::SUM_W;

   logic [31:0]                   hash_ff;
   logic [SW-1:0]                 sum_ff, sum_in;
   logic [hll_pkg::EMPTY_W-1:0]   empty_ff, empty_in;
   logic [NW-1:0]                 num_ff, q_ff;
   logic [SW-1:0]                 rem_ff;
   logic [NW:0]                   e_ff;
   logic [31:0]                   res_ff, est_ff, x_ff, m_ff;
   logic                          small_ff;
   logic [5:0]                    base_ff;
   logic [4:0]                    p_ff;
   logic [31:0]                   frac_ff;
   logic [37:0]                   lnq_ff;

   logic                          ram_we;
   logic [LMB-1:0]                ram_waddr, ram_raddr, idx_mask;
   logic [hll_pkg::RANK_W-1:0]    ram_wdata, old_rank, rank;
   logic [31:0]                   g;
   logic [5:0]                    lz, rank6;
   logic [4:0]                    g_top, x_top;
   logic [SW:0]                   div_t;
   logic                          div_ge;
   logic [NW+1:0]                 two_e, five_k;
   logic [NW+2:0]                 three_e;
   logic                          is_small, is_large, ge32, need_log;
   logic [63:0]                   sq;
   logic [32:0]                   sq_sh;
   logic [37:0]                   d;
   logic [53:0]                   lnp;
   logic [51:0]                   lin;

   assign idx_mask  = ~({LMB{1'b1}} << log_k);
   assign ram_raddr = req_hash_value[LMB-1:0] & idx_mask;

   hll_ram #(.WIDTH(hll_pkg::RANK_W), .DEPTH(hll_pkg::MAX_BUCKETS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (old_rank)
   );

   always_comb begin
      g     = hash_ff >> log_k;
      g_top = '0;
      for (int i = 0; i < 32; i++) begin
         if (g[i]) g_top = 5'(i);
      end
      lz    = (g == '0) ? 6'd32 : 6'd31 - 6'(g_top);
      rank6 = lz + 6'd1 - 6'(log_k);
      rank  = rank6[4:0];
   end

   always_comb begin
      ram_we    = cmd.clr_wr;
      ram_waddr = cmd.clr_addr;
      ram_wdata = '0;
      sum_in    = sum_ff;
      empty_in  = empty_ff;
      if (cmd.clr_init) begin
         sum_in   = SW'(1) << (6'(log_k) + 6'd29);
         empty_in = hll_pkg::EMPTY_W'(1) << log_k;
      end else if (cmd.ins_upd && (rank > old_rank)) begin
         ram_we    = 1'b1;
         ram_waddr = hash_ff[LMB-1:0] & idx_mask;
         ram_wdata = rank;
         sum_in    = sum_ff - (SW'(1) << (5'd29 - old_rank))
                     + (SW'(1) << (5'd29 - rank));
         if ((old_rank == '0) && (empty_ff != '0)) empty_in = empty_ff - 1'b1;
      end
   end

   assign div_t  = {rem_ff, num_ff[NW-1]};
   assign div_ge = div_t >= {1'b0, sum_ff};

   always_comb begin
      two_e    = {e_ff, 1'b0};
      five_k   = (NW+2)'(5) << log_k;
      three_e  = {1'b0, e_ff, 1'b0} + (NW+3)'(e_ff);
      is_small = two_e < five_k;
      is_large = three_e > (NW+3)'(64'h1_0000_0000);
      ge32     = |e_ff[NW:32];
      need_log = (is_small && (empty_ff != '0)) || (!is_small && is_large && !ge32);
      sts.need_log = need_log;
   end

   always_comb begin
      x_top = '0;
      for (int i = 0; i < 32; i++) begin
         if (x_ff[i]) x_top = 5'(i);
      end
      sq    = 64'(m_ff) * 64'(m_ff);
      sq_sh = sq[63:31];
      d     = {base_ff, 32'd0} - {1'b0, p_ff, frac_ff};
      lnp   = 54'(d[37:16]) * 54'(hll_pkg::LN2_Q32);
      lin   = (52'(lnq_ff) << log_k);
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      empty_ff <= empty_in;
      if (cmd.accept) begin
         hash_ff <= req_hash_value;
         num_ff  <= NW'(bias) << (6'(log_k) * 6'd2 + 6'd13);
         rem_ff  <= '0;
         q_ff    <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= div_ge ? SW'(div_t - {1'b0, sum_ff}) : div_t[SW-1:0];
         q_ff   <= {q_ff[NW-2:0], div_ge};
         num_ff <= {num_ff[NW-2:0], 1'b0};
      end
      if (cmd.div_end) begin
         e_ff <= (NW+1)'(q_ff) + (NW+1)'(rem_ff != '0);
      end
      if (cmd.decide) begin
         small_ff <= is_small;
         base_ff  <= is_small ? 6'(log_k) : 6'd32;
         x_ff     <= is_small ? 32'(empty_ff) : 32'(64'h1_0000_0000 - 64'(e_ff));
         res_ff   <= ge32 ? 32'hFFFF_FFFF : e_ff[31:0];
      end
      if (cmd.log_norm) begin
         p_ff    <= x_top;
         m_ff    <= x_ff << (5'd31 - x_top);
         frac_ff <= '0;
      end
      if (cmd.log_step) begin
         frac_ff <= {frac_ff[30:0], sq_sh[32]};
         m_ff    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
      end
      if (cmd.ln_mul) begin
         lnq_ff <= lnp[53:16];
      end
      if (cmd.ln_res) begin
         if (small_ff) begin
            res_ff <= 32'(lin[51:32]);
         end else begin
            res_ff <= (|lnq_ff[37:32]) ? 32'hFFFF_FFFF : lnq_ff[31:0];
         end
      end
      if (cmd.load_out) begin
         est_ff <= res_ff;
      end
   end

   assign rsp_estimate = est_ff;

endmodule
`default_nettype wire
